// ===== hw/rtl/mts_pkg.sv =====
package mts_pkg;

  // default table depth
  localparam int MAX_NOTES = 256;

  // field widths
  localparam int FREQ_W  = 16;
  localparam int DUR_W   = 32;
  localparam int NIDX_W  = 8;
  localparam int CNT_W   = 9;
  localparam int TIME_W  = 32;
  localparam int SLOT_W  = 16;
  localparam int ENTRY_W = FREQ_W + SLOT_W;
  localparam int DUTY_W  = 7;

  // duty factor: ceil(duty * 2^MULT_SHIFT / 100), exact floor for 16-bit slots
  localparam int MULT_SHIFT = 23;
  localparam int MULT_W     = 24;

  typedef enum logic [2:0] {
    CMD_TICK        = 3'd0,
    CMD_PLAY_TONE   = 3'd1,
    CMD_STOP_TONE   = 3'd2,
    CMD_LOAD_NOTE   = 3'd3,
    CMD_PLAY_MELODY = 3'd4,
    CMD_STOP_MELODY = 3'd5
  } cmd_t;

  typedef struct packed {
    cmd_t               command;
    logic [FREQ_W-1:0]  frequency_hz;
    logic [DUR_W-1:0]   duration_ms;
    logic [NIDX_W-1:0]  note_index;
    logic [CNT_W-1:0]   note_count;
    logic               loop_melody;
  } item_t;

  typedef struct packed {
    logic [FREQ_W-1:0] drive_frequency;
    logic              sounding;
    logic              melody_running;
  } result_t;

endpackage

// ===== hw/rtl/melody_tone_sequencer.sv =====
// channel  dir  handshake          payload
// s        in   s_tvalid/s_tready  s_tuser command, s_tdata note fields
// m        out  m_tvalid/m_tready  m_tdata drive frequency and status
// apb      in   psel/penable       duty_percent at byte address 0
//
// one transfer in gives one transfer out; an item can be taken every cycle while the m side is not stalled
// an item passes through the input register, then the step logic into the result register
// the note table prefetches the next entry from its registered read port, so
// the step never waits on the memory
// rst is synchronous and clears the sequencer state but not cur_slot or the note table; duty_percent returns to 85
// a stalled m side holds the result and blocks s only when both registers are full
module melody_tone_sequencer #(
  parameter int MAX_NOTES = mts_pkg::MAX_NOTES
) (
  input  logic        clk,
  input  logic        rst,
  // stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // frequency_hz, duration_ms, note_index, note_count, loop_melody
  input  logic [2:0]  s_tuser,  // command
  // stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // drive_frequency, sounding, melody_running
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                       in_vld;
  mts_pkg::item_t             in_item;
  mts_pkg::result_t           step_res;
  mts_pkg::result_t           out_res;
  logic                       advance;
  logic [mts_pkg::MULT_W-1:0] duty_factor;

  // the step fires when the result register is free or being drained
  assign advance  = in_vld && (!m_tvalid || m_tready);
  assign s_tready = !in_vld || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.command      <= mts_pkg::cmd_t'(s_tuser);
      in_item.frequency_hz <= s_tdata[15:0];
      in_item.duration_ms  <= s_tdata[47:16];
      in_item.note_index   <= s_tdata[55:48];
      in_item.note_count   <= s_tdata[64:56];
      in_item.loop_melody  <= s_tdata[65];
    end
  end

  mts_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .duty_factor (duty_factor)
  );

  mts_core #(
    .MAX_NOTES (MAX_NOTES)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .item        (in_item),
    .duty_factor (duty_factor),
    .result      (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign m_tdata = {6'b0, out_res.melody_running, out_res.sounding, out_res.drive_frequency};

endmodule

// ===== hw/rtl/mts_ram.sv =====
module mts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/mts_cfg.sv =====
module mts_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output logic [mts_pkg::MULT_W-1:0]      duty_factor
);

  localparam logic [mts_pkg::DUTY_W-1:0] DUTY_RESET  = 7'd85;
  localparam logic [mts_pkg::DUTY_W-1:0] DUTY_MAX    = 7'd100;
  // floor(2^23 / 100)
  localparam logic [mts_pkg::MULT_W-1:0] RECIP       = 24'd83886;
  localparam logic [mts_pkg::MULT_W-1:0] FACTOR_INIT = 24'd7130317;

  logic [mts_pkg::DUTY_W-1:0] duty;
  logic [mts_pkg::DUTY_W-1:0] wr_duty;
  logic [mts_pkg::DUTY_W-1:0] duty_clamp;
  logic [3:0]                 frac_up;
  logic [mts_pkg::MULT_W-1:0] factor_next;
  logic                       wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && !paddr[2];
  assign wr_duty = pwdata[mts_pkg::DUTY_W-1:0];

  // ceil(0.08 * d) by thresholds of 12.5
  always_comb begin
    duty_clamp  = (wr_duty > DUTY_MAX) ? DUTY_MAX : wr_duty;
    frac_up     = 4'(duty_clamp > 7'd0)  + 4'(duty_clamp > 7'd12) + 4'(duty_clamp > 7'd25)
                + 4'(duty_clamp > 7'd37) + 4'(duty_clamp > 7'd50) + 4'(duty_clamp > 7'd62)
                + 4'(duty_clamp > 7'd75) + 4'(duty_clamp > 7'd87);
    factor_next = 24'(RECIP * {17'b0, duty_clamp}) + {20'b0, frac_up};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty        <= DUTY_RESET;
      duty_factor <= FACTOR_INIT;
    end else if (wr_en) begin
      duty        <= wr_duty;
      duty_factor <= factor_next;
    end
  end

  assign prdata = paddr[2] ? 32'b0 : {25'b0, duty};

endmodule

// ===== hw/rtl/mts_core.sv =====
module mts_core #(
  parameter int MAX_NOTES = mts_pkg::MAX_NOTES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  mts_pkg::item_t              item,
  input  logic [mts_pkg::MULT_W-1:0]  duty_factor,
  output mts_pkg::result_t            result
);

  localparam int          IDX_W = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam logic [13:0] MAXN  = 14'(MAX_NOTES);

  // sequencer state
  logic [31:0]      time_now,   time_now_next;
  logic [31:0]      tone_dl,    tone_dl_next;
  logic [31:0]      note_dl,    note_dl_next;
  logic             active,     active_next;
  logic             gap_phase,  gap_phase_next;
  logic [IDX_W-1:0] pos,        pos_next;
  logic [8:0]       len,        len_next;
  logic             loop_mode,  loop_mode_next;
  logic             playing,    playing_next;
  logic [15:0]      drive,      drive_next;
  // slot length of the table entry at pos
  logic [15:0]      cur_slot,   cur_slot_next;

  // table access
  logic [31:0]      entry0;
  logic [31:0]      ram_q;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] rd_addr_q;
  logic             wr_vld_q;
  logic [IDX_W-1:0] wr_addr_q;
  logic [31:0]      wr_data_q;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [31:0]      wdata;
  logic [31:0]      next_entry;

  // step datapath
  logic [31:0]      t1;
  logic [31:0]      tone_diff;
  logic [31:0]      note_diff;
  logic             tone_hit;
  logic             note_hit;
  logic [13:0]      np_ext;
  logic             wrap;
  logic             use_first;
  logic [31:0]      entry_sel;
  logic [15:0]      slot;
  logic [39:0]      prod;
  logic [15:0]      on_ms;
  logic [15:0]      on_len;
  logic [15:0]      gap_len;
  logic [15:0]      gap_use;
  logic [31:0]      tbase;
  logic [31:0]      begin_dl;
  logic [15:0]      dur_sat;
  logic [8:0]       len_clamp;
  logic             halt;
  logic             start_note;

  assign dur_sat = (|item.duration_ms[31:16]) ? 16'hFFFF : item.duration_ms[15:0];
  assign we      = step && (item.command == mts_pkg::CMD_LOAD_NOTE)
                && ({6'b0, item.note_index} < MAXN);
  assign waddr   = IDX_W'(item.note_index);
  assign wdata   = {dur_sat, item.frequency_hz};
  assign rd_addr = pos + IDX_W'(1);

  mts_ram #(
    .WIDTH (mts_pkg::ENTRY_W),
    .DEPTH (MAX_NOTES),
    .AW    (IDX_W)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // a write on the same edge as the read is not yet in ram_q
  assign next_entry = (wr_vld_q && (wr_addr_q == rd_addr_q)) ? wr_data_q : ram_q;

  always_comb begin
    t1        = time_now + 32'd1;
    tone_diff = t1 - tone_dl;
    note_diff = t1 - note_dl;
    tone_hit  = (tone_dl != 32'd0) && !tone_diff[31];
    note_hit  = !note_diff[31];
    np_ext    = 14'(pos) + 14'd1;
    wrap      = np_ext >= {5'b0, len};
    use_first = (item.command != mts_pkg::CMD_TICK) || wrap;
    entry_sel = use_first ? entry0 : next_entry;
    // gap entry splits the sounding note, a note start splits the selected entry
    slot      = ((item.command == mts_pkg::CMD_TICK) && !gap_phase) ? cur_slot
                                                                    : entry_sel[31:16];
    prod      = {24'b0, slot} * {16'b0, duty_factor};
    on_ms     = prod[mts_pkg::MULT_SHIFT +: 16];
    on_len    = (on_ms == 16'd0) ? 16'd1 : on_ms;
    gap_len   = slot - on_ms;
    gap_use   = (gap_len == 16'd0) ? 16'd1 : gap_len;
    tbase     = (item.command == mts_pkg::CMD_TICK) ? t1 : time_now;
    begin_dl  = tbase + {16'b0, on_len};
    len_clamp = ({5'b0, item.note_count} > MAXN) ? MAXN[8:0] : item.note_count;
  end

  always_comb begin
    time_now_next  = time_now;
    tone_dl_next   = tone_dl;
    note_dl_next   = note_dl;
    active_next    = active;
    gap_phase_next = gap_phase;
    pos_next       = pos;
    len_next       = len;
    loop_mode_next = loop_mode;
    playing_next   = playing;
    drive_next     = drive;
    cur_slot_next  = cur_slot;
    start_note     = 1'b0;

    halt = (item.command == mts_pkg::CMD_PLAY_TONE)
        || (item.command == mts_pkg::CMD_STOP_TONE)
        || (item.command == mts_pkg::CMD_STOP_MELODY);

    if (halt) begin
      if (active) begin
        drive_next   = 16'd0;
        playing_next = 1'b0;
      end
      active_next    = 1'b0;
      len_next       = 9'd0;
      pos_next       = '0;
      gap_phase_next = 1'b0;
      note_dl_next   = 32'd0;
    end

    unique case (item.command)
      mts_pkg::CMD_TICK: begin
        time_now_next = t1;
        if (tone_hit) begin
          drive_next   = 16'd0;
          tone_dl_next = 32'd0;
          playing_next = 1'b0;
        end
        if (active && note_hit) begin
          if (!gap_phase) begin
            drive_next     = 16'd0;
            gap_phase_next = 1'b1;
            note_dl_next   = t1 + {16'b0, gap_use};
          end else if (wrap && !loop_mode) begin
            drive_next     = 16'd0;
            playing_next   = 1'b0;
            active_next    = 1'b0;
            len_next       = 9'd0;
            pos_next       = '0;
            gap_phase_next = 1'b0;
            note_dl_next   = 32'd0;
          end else begin
            pos_next   = wrap ? '0 : np_ext[IDX_W-1:0];
            start_note = 1'b1;
          end
        end
      end
      mts_pkg::CMD_PLAY_TONE: begin
        drive_next   = item.frequency_hz;
        tone_dl_next = (item.duration_ms != 32'd0) ? time_now + item.duration_ms : 32'd0;
        playing_next = item.frequency_hz != 16'd0;
      end
      mts_pkg::CMD_STOP_TONE: begin
        drive_next   = 16'd0;
        tone_dl_next = 32'd0;
        playing_next = 1'b0;
      end
      mts_pkg::CMD_PLAY_MELODY: begin
        if (item.note_count != 9'd0) begin
          active_next    = 1'b1;
          len_next       = len_clamp;
          pos_next       = '0;
          loop_mode_next = item.loop_melody;
          tone_dl_next   = 32'd0;
          start_note     = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // reloading the entry under the current note changes its gap
    if (we && (waddr == pos)) begin
      cur_slot_next = dur_sat;
    end

    if (start_note) begin
      drive_next     = entry_sel[15:0];
      gap_phase_next = 1'b0;
      note_dl_next   = begin_dl;
      playing_next   = 1'b1;
      cur_slot_next  = entry_sel[31:16];
    end
  end

  assign result.drive_frequency = drive_next;
  assign result.sounding        = playing_next;
  assign result.melody_running  = active_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now  <= 32'd0;
      tone_dl   <= 32'd0;
      note_dl   <= 32'd0;
      active    <= 1'b0;
      gap_phase <= 1'b0;
      pos       <= '0;
      len       <= 9'd0;
      loop_mode <= 1'b0;
      playing   <= 1'b0;
      drive     <= 16'd0;
    end else if (step) begin
      time_now  <= time_now_next;
      tone_dl   <= tone_dl_next;
      note_dl   <= note_dl_next;
      active    <= active_next;
      gap_phase <= gap_phase_next;
      pos       <= pos_next;
      len       <= len_next;
      loop_mode <= loop_mode_next;
      playing   <= playing_next;
      drive     <= drive_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_vld_q <= 1'b0;
    end else begin
      wr_vld_q <= we;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_q <= rd_addr;
    wr_addr_q <= waddr;
    wr_data_q <= wdata;
    if (step) begin
      cur_slot <= cur_slot_next;
    end
    if (we && (waddr == '0)) begin
      entry0 <= wdata;
    end
  end

endmodule
